/* rtl/hdtp_pkg.sv */
`default_nettype none
package hdtp_pkg;

	// Heading geometry in 1/64 degree
	localparam logic [16:0] ERR_WRAP_LIMIT = 17'd11520;
	localparam logic [17:0] ERR_FULL_TURN  = 18'd23040;
	localparam logic [16:0] DEADBAND       = 17'd96;
	// 0.6 drive in 2^-14 units, rounded down
	localparam logic [41:0] SETTLE_LIMIT   = 42'd9830;
	localparam logic [15:0] TICK_MAX       = 16'hFFFF;

	// Register reset values
	localparam logic [15:0] RST_GAIN_P    = 16'd256;
	localparam logic [15:0] RST_GAIN_I    = 16'd0;
	localparam logic [15:0] RST_GAIN_D    = 16'd0;
	localparam logic [15:0] RST_INT_LIMIT = 16'd640;
	localparam logic [6:0]  RST_MIN_DRIVE = 7'd18;
	localparam logic [6:0]  RST_MAX_DRIVE = 7'd60;
	localparam logic [15:0] RST_SCALE     = 16'd256;
	localparam logic [15:0] RST_TIMEOUT   = 16'd500;

	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_INT_LIMIT = 3'd3,
		REG_MIN_DRIVE = 3'd4,
		REG_MAX_DRIVE = 3'd5,
		REG_SCALE     = 3'd6,
		REG_TIMEOUT   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_RUN     = 2'd0,
		CAUSE_SETTLED = 2'd1,
		CAUSE_OSC     = 2'd2,
		CAUSE_TIMEOUT = 2'd3
	} cause_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_EVAL,
		OP_WRAP,
		OP_INTEG,
		OP_CLAMP,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_P,
		MS_I,
		MS_D,
		MS_C
	} msel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		acc_t  acc;
		logic  jz;      // step may emit; return to idle when it does
	} cw_t;

	typedef struct packed {
		logic  en;
		op_t   op;
		msel_t msel;
		acc_t  acc;
	} ctrl_t;

	typedef struct packed {
		logic              fire;
		logic signed [7:0] drive;
		logic              done;
		cause_t            cause;
	} res_t;

	typedef struct packed {
		logic        [15:0] gain_p;
		logic        [15:0] gain_i;
		logic        [15:0] gain_d;
		logic signed [15:0] integral_limit;
		logic        [6:0]  min_drive;
		logic        [6:0]  max_drive;
		logic signed [15:0] drive_scale;
		logic        [15:0] timeout_ticks;
	} cfg_t;

	typedef logic [3:0] pc_t;

	localparam pc_t PC_IDLE   = 4'd0;
	localparam pc_t PC_EVAL   = 4'd1;
	localparam pc_t PC_WRAP   = 4'd2;
	localparam pc_t PC_INTEG  = 4'd3;
	localparam pc_t PC_MUL_P  = 4'd4;
	localparam pc_t PC_MUL_I  = 4'd5;
	localparam pc_t PC_MUL_D  = 4'd6;
	localparam pc_t PC_SUM    = 4'd7;
	localparam pc_t PC_CLAMP  = 4'd8;
	localparam pc_t PC_MUL_C  = 4'd9;
	localparam pc_t PC_FINISH = 4'd10;

	function automatic cw_t ucode(input pc_t pc);
		cw_t cw;
		cw = '{op: OP_NOP, msel: MS_NONE, acc: ACC_HOLD, jz: 1'b0};
		case (pc)
			PC_EVAL: begin
				cw.op = OP_EVAL;
				cw.jz = 1'b1;
			end
			PC_WRAP:  cw.op = OP_WRAP;
			PC_INTEG: cw.op = OP_INTEG;
			PC_MUL_P: cw.msel = MS_P;
			PC_MUL_I: begin
				cw.msel = MS_I;
				cw.acc  = ACC_LOAD;
			end
			PC_MUL_D: begin
				cw.msel = MS_D;
				cw.acc  = ACC_ADD;
			end
			PC_SUM: cw.acc = ACC_ADD;
			PC_CLAMP: begin
				cw.op = OP_CLAMP;
				cw.jz = 1'b1;
			end
			PC_MUL_C: cw.msel = MS_C;
			PC_FINISH: begin
				cw.op = OP_FINISH;
				cw.jz = 1'b1;
			end
			default: cw.op = OP_NOP;
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

/* rtl/hdtp_dp.sv */
`default_nettype none
module hdtp_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hdtp_pkg::ctrl_t    ctrl,
	input  wire hdtp_pkg::cfg_t     cfg,
	input  wire logic               start_req,
	input  wire logic signed [15:0] target_heading,
	input  wire logic signed [15:0] measured_heading,
	output hdtp_pkg::res_t          res
);

	// Controller state
	logic               moving_q;
	logic               first_q;
	logic               last_sign_q;
	logic [1:0]         flip_q;
	logic [15:0]        tick_q;
	logic signed [15:0] last_err_q;
	logic signed [23:0] integ_q;

	// Working registers
	logic signed [16:0] eraw_q;
	logic signed [15:0] e_q;
	logic signed [16:0] deriv_q;
	logic signed [41:0] prod_q;
	logic signed [41:0] acc_q;
	logic [20:0]        c_q;
	logic               sneg_q;

	// Evaluate step
	logic               mov_n, first_n;
	logic [15:0]        tick_n;
	logic signed [16:0] eraw;
	logic               sign_pos;
	logic [1:0]         flip_base, flip_new;
	logic               osc;

	assign mov_n   = start_req | moving_q;
	assign first_n = start_req | first_q;
	assign tick_n  = start_req ? 16'd0 : tick_q;
	assign eraw    = {measured_heading[15], measured_heading}
	               - {target_heading[15], target_heading};
	assign sign_pos  = !eraw[16] && (eraw != 17'sd0);
	assign flip_base = first_n ? 2'd0 : flip_q;
	assign flip_new  = flip_base + 2'(!first_n && (sign_pos != last_sign_q)
	                                  && (flip_base != 2'd3));
	assign osc = flip_new[1];

	// Wrap step
	logic [16:0]        rmag;
	logic signed [17:0] wdiff, wrapped;
	logic signed [15:0] e_sat;

	assign rmag  = eraw_q[16] ? 17'(-eraw_q) : 17'(eraw_q);
	assign wdiff = $signed(hdtp_pkg::ERR_FULL_TURN - {1'b0, rmag});
	always_comb begin
		if (rmag > hdtp_pkg::ERR_WRAP_LIMIT) begin
			wrapped = eraw_q[16] ? wdiff : -wdiff;
		end else begin
			wrapped = {eraw_q[16], eraw_q};
		end
		if (wrapped > 18'sd32767) begin
			e_sat = 16'sh7FFF;
		end else if (wrapped < -18'sd32768) begin
			e_sat = 16'sh8000;
		end else begin
			e_sat = wrapped[15:0];
		end
	end

	// Integrate step
	logic signed [16:0] e_ext;
	logic [16:0]        emag;
	logic               integ_ok;
	logic signed [24:0] isum;
	logic signed [23:0] isat;
	logic signed [16:0] deriv_n;

	assign e_ext    = {e_q[15], e_q};
	assign emag     = e_q[15] ? 17'(-e_ext) : 17'(e_ext);
	assign integ_ok = (emag > hdtp_pkg::DEADBAND) && (e_q < cfg.integral_limit);
	assign isum     = {integ_q[23], integ_q} + 25'(e_ext);
	always_comb begin
		if (isum > 25'sd8388607) begin
			isat = 24'sh7FFFFF;
		end else if (isum < -25'sd8388608) begin
			isat = 24'sh800000;
		end else begin
			isat = isum[23:0];
		end
	end
	assign deriv_n = first_q ? 17'sd0 : e_ext - {last_err_q[15], last_err_q};

	// Shared multiplier
	logic signed [24:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [41:0] prod_n;

	always_comb begin
		case (ctrl.msel)
			hdtp_pkg::MS_P: begin
				mul_a = 25'(e_q);
				mul_b = $signed({1'b0, cfg.gain_p});
			end
			hdtp_pkg::MS_I: begin
				mul_a = 25'(integ_q);
				mul_b = $signed({1'b0, cfg.gain_i});
			end
			hdtp_pkg::MS_D: begin
				mul_a = 25'(deriv_q);
				mul_b = $signed({1'b0, cfg.gain_d});
			end
			hdtp_pkg::MS_C: begin
				mul_a = $signed({4'b0, c_q});
				mul_b = 17'(cfg.drive_scale);
			end
			default: begin
				mul_a = 25'sd0;
				mul_b = 17'sd0;
			end
		endcase
	end
	assign prod_n = mul_a * mul_b;

	// Clamp step
	logic [41:0] sabs, lo, hi, c_lo;
	logic        settled;

	assign sabs    = acc_q[41] ? 42'(-acc_q) : 42'(acc_q);
	assign settled = sabs <= hdtp_pkg::SETTLE_LIMIT;
	assign lo      = {21'b0, cfg.min_drive, 14'b0};
	assign hi      = {21'b0, cfg.max_drive, 14'b0};
	assign c_lo    = (sabs < lo) ? lo : sabs;

	// Finish step
	logic        pneg;
	logic [41:0] pmag;
	logic [6:0]  dmag;
	logic signed [7:0] drive_n;
	logic [15:0] tick_inc;
	logic        tout;

	assign pneg     = prod_q[41];
	assign pmag     = pneg ? 42'(-prod_q) : 42'(prod_q);
	assign dmag     = (pmag[41:22] > 20'd127) ? 7'd127 : pmag[28:22];
	assign drive_n  = (sneg_q ^ pneg) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
	assign tick_inc = (tick_q != hdtp_pkg::TICK_MAX) ? tick_q + 16'd1 : tick_q;
	assign tout     = tick_inc >= cfg.timeout_ticks;

	always_comb begin
		res = '{fire: 1'b0, drive: 8'sd0, done: 1'b0, cause: hdtp_pkg::CAUSE_RUN};
		case (ctrl.op)
			hdtp_pkg::OP_EVAL: begin
				if (!mov_n) begin
					res.fire = 1'b1;
				end else if (osc) begin
					res.fire  = 1'b1;
					res.done  = 1'b1;
					res.cause = hdtp_pkg::CAUSE_OSC;
				end
			end
			hdtp_pkg::OP_CLAMP: begin
				if (settled) begin
					res.fire  = 1'b1;
					res.done  = 1'b1;
					res.cause = hdtp_pkg::CAUSE_SETTLED;
				end
			end
			hdtp_pkg::OP_FINISH: begin
				res.fire = 1'b1;
				if (tout) begin
					res.done  = 1'b1;
					res.cause = hdtp_pkg::CAUSE_TIMEOUT;
				end else begin
					res.drive = drive_n;
				end
			end
			default: res.fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q    <= 1'b1;
			first_q     <= 1'b1;
			last_sign_q <= 1'b0;
			flip_q      <= 2'd0;
			tick_q      <= 16'd0;
			last_err_q  <= 16'sd0;
			integ_q     <= 24'sd0;
		end else if (ctrl.en) begin
			case (ctrl.op)
				hdtp_pkg::OP_EVAL: begin
					if (mov_n) begin
						first_q     <= first_n;
						tick_q      <= tick_n;
						flip_q      <= flip_new;
						last_sign_q <= sign_pos;
						moving_q    <= !osc;
						if (first_n) begin
							last_err_q <= 16'sd0;
							integ_q    <= 24'sd0;
						end
					end
				end
				hdtp_pkg::OP_INTEG: begin
					integ_q    <= integ_ok ? isat : 24'sd0;
					last_err_q <= e_q;
					first_q    <= 1'b0;
				end
				hdtp_pkg::OP_CLAMP: begin
					if (settled) begin
						moving_q <= 1'b0;
					end
				end
				hdtp_pkg::OP_FINISH: begin
					tick_q <= tick_inc;
					if (tout) begin
						moving_q <= 1'b0;
					end
				end
				default: moving_q <= moving_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				hdtp_pkg::OP_EVAL:  eraw_q <= eraw;
				hdtp_pkg::OP_WRAP:  e_q <= e_sat;
				hdtp_pkg::OP_INTEG: deriv_q <= deriv_n;
				hdtp_pkg::OP_CLAMP: begin
					c_q    <= (c_lo > hi) ? hi[20:0] : c_lo[20:0];
					sneg_q <= acc_q[41];
				end
				default: eraw_q <= eraw_q;
			endcase
			if (ctrl.msel != hdtp_pkg::MS_NONE) begin
				prod_q <= prod_n;
			end
			case (ctrl.acc)
				hdtp_pkg::ACC_LOAD: acc_q <= prod_q;
				hdtp_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
				default:            acc_q <= acc_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/heading_turn_pid.sv */
// A running tick's result is emitted by the finish step, an idle or
// oscillation tick's by the evaluate step, a settled tick's by the clamp step.
// A new item is taken only once the ten-step control program is back at idle;
// it runs the P, I, D and scale products through one shared multiplier.
// Reset: registers return to defaults and the controller is armed, as if a
// move had just started; no clearing pass.
`default_nettype none
module heading_turn_pid (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // target_heading, measured_heading
	input  wire logic        s_tuser,   // start_req
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // drive
	output logic             m_tlast,   // done_res
	output logic [1:0]       m_tuser,   // end_cause
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	hdtp_pkg::cfg_t  cfg_q;
	hdtp_pkg::pc_t   pc_q, pc_d;
	hdtp_pkg::cw_t   cw;
	hdtp_pkg::ctrl_t ctrl;
	hdtp_pkg::res_t  res;

	logic               start_q;
	logic signed [15:0] targ_q, meas_q;
	logic               s_accept, stall, step_en, emit;
	hdtp_pkg::reg_idx_t ridx;

	// Configuration port
	assign pready = 1'b1;
	assign ridx   = hdtp_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= hdtp_pkg::RST_GAIN_P;
			cfg_q.gain_i         <= hdtp_pkg::RST_GAIN_I;
			cfg_q.gain_d         <= hdtp_pkg::RST_GAIN_D;
			cfg_q.integral_limit <= hdtp_pkg::RST_INT_LIMIT;
			cfg_q.min_drive      <= hdtp_pkg::RST_MIN_DRIVE;
			cfg_q.max_drive      <= hdtp_pkg::RST_MAX_DRIVE;
			cfg_q.drive_scale    <= hdtp_pkg::RST_SCALE;
			cfg_q.timeout_ticks  <= hdtp_pkg::RST_TIMEOUT;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				hdtp_pkg::REG_GAIN_P:    cfg_q.gain_p         <= pwdata[15:0];
				hdtp_pkg::REG_GAIN_I:    cfg_q.gain_i         <= pwdata[15:0];
				hdtp_pkg::REG_GAIN_D:    cfg_q.gain_d         <= pwdata[15:0];
				hdtp_pkg::REG_INT_LIMIT: cfg_q.integral_limit <= pwdata[15:0];
				hdtp_pkg::REG_MIN_DRIVE: cfg_q.min_drive      <= pwdata[6:0];
				hdtp_pkg::REG_MAX_DRIVE: cfg_q.max_drive      <= pwdata[6:0];
				hdtp_pkg::REG_SCALE:     cfg_q.drive_scale    <= pwdata[15:0];
				hdtp_pkg::REG_TIMEOUT:   cfg_q.timeout_ticks  <= pwdata[15:0];
				default:                 cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			hdtp_pkg::REG_GAIN_P:    prdata = {16'b0, cfg_q.gain_p};
			hdtp_pkg::REG_GAIN_I:    prdata = {16'b0, cfg_q.gain_i};
			hdtp_pkg::REG_GAIN_D:    prdata = {16'b0, cfg_q.gain_d};
			hdtp_pkg::REG_INT_LIMIT: prdata = {16'b0, cfg_q.integral_limit};
			hdtp_pkg::REG_MIN_DRIVE: prdata = {25'b0, cfg_q.min_drive};
			hdtp_pkg::REG_MAX_DRIVE: prdata = {25'b0, cfg_q.max_drive};
			hdtp_pkg::REG_SCALE:     prdata = {16'b0, cfg_q.drive_scale};
			hdtp_pkg::REG_TIMEOUT:   prdata = {16'b0, cfg_q.timeout_ticks};
			default:                 prdata = 32'b0;
		endcase
	end

	// Sequencer
	assign cw       = hdtp_pkg::ucode(pc_q);
	assign s_tready = (pc_q == hdtp_pkg::PC_IDLE);
	assign s_accept = s_tvalid && s_tready;
	// hold a step that may emit while the previous result is still waiting
	assign stall    = cw.jz && m_tvalid && !m_tready;
	assign step_en  = (pc_q != hdtp_pkg::PC_IDLE) && !stall;
	assign emit     = step_en && res.fire;

	assign ctrl = '{en: step_en, op: cw.op, msel: cw.msel, acc: cw.acc};

	always_comb begin
		pc_d = pc_q;
		if (s_accept) begin
			pc_d = hdtp_pkg::PC_EVAL;
		end else if (step_en) begin
			if (cw.jz && res.fire) begin
				pc_d = hdtp_pkg::PC_IDLE;
			end else begin
				pc_d = pc_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hdtp_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			start_q <= s_tuser;
			targ_q  <= s_tdata[15:0];
			meas_q  <= s_tdata[31:16];
		end
	end

	hdtp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.cfg              (cfg_q),
		.start_req        (start_q),
		.target_heading   (targ_q),
		.measured_heading (meas_q),
		.res              (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= res.drive;
			m_tlast <= res.done;
			m_tuser <= res.cause;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> pc_q == hdtp_pkg::PC_EVAL)
		else $error("accepted item did not start the program");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(m_tvalid && !m_tready))
		else $error("result emitted over a pending result");

	a_done_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata == 8'd0)
		else $error("ending tick carries nonzero drive");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != hdtp_pkg::CAUSE_RUN)))
		else $error("done flag and end cause disagree");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= hdtp_pkg::PC_FINISH)
		else $error("step counter beyond program");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
	import hdtp_pkg::*;

	localparam longint DRIVE_ONE   = 16384;  // one drive unit in 2^-14 steps
	localparam int     SCALE_SHIFT = 22;

	typedef struct packed {
		logic signed [7:0] drive;
		logic              done;
		cause_t            cause;
	} tick_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // target_heading, measured_heading
	logic        s_tuser;   // start_req
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // drive
	logic        m_tlast;   // done_res
	logic [1:0]  m_tuser;   // end_cause
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heading_turn_pid u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Controller model state and register copy
	cfg_t cfg_now;
	bit   mv_active   = 1'b1;
	bit   mv_first    = 1'b1;
	bit   mv_last_pos = 1'b0;
	int   mv_last_err = 0;
	int   mv_integral = 0;
	int   mv_flips    = 0;
	int   mv_ticks    = 0;

	tick_res_t pending_ticks[$];
	tick_res_t got_want;
	int        n_bad    = 0;
	int        n_sent   = 0;
	bit        gapless  = 1'b0;
	int        hold_req = 0;
	int        hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic tick_res_t heading_step(bit start, logic signed [15:0] tgt,
			logic signed [15:0] meas);
		int     e, mag, deriv, acc, lim;
		longint s, c, lo, hi, prod, pmag;
		bit     pos;
		tick_res_t r;
		r.drive = '0;
		r.done  = 1'b0;
		r.cause = CAUSE_RUN;
		if (start) begin
			mv_active = 1'b1;
			mv_first  = 1'b1;
			mv_ticks  = 0;
		end
		if (!mv_active)
			return r;
		if (mv_first) begin
			mv_last_err = 0;
			mv_flips    = 0;
			mv_integral = 0;
		end
		e   = meas - tgt;
		pos = (e > 0);
		// sign is taken before wrapping
		if (!mv_first && pos != mv_last_pos && mv_flips < 3)
			mv_flips++;
		mv_last_pos = pos;
		if (mv_flips > 1) begin
			mv_active = 1'b0;
			r.done    = 1'b1;
			r.cause   = CAUSE_OSC;
			return r;
		end
		mag = (e < 0) ? -e : e;
		if (mag > int'(ERR_WRAP_LIMIT))
			e = (e < 0) ? int'(ERR_FULL_TURN) - mag : mag - int'(ERR_FULL_TURN);
		if (e > 32767)
			e = 32767;
		if (e < -32768)
			e = -32768;
		mag = (e < 0) ? -e : e;
		lim = int'($signed(cfg_now.integral_limit));
		if (mag > int'(DEADBAND) && e < lim) begin
			acc = mv_integral + e;
			if (acc > 8388607)
				acc = 8388607;
			if (acc < -8388608)
				acc = -8388608;
			mv_integral = acc;
		end else begin
			mv_integral = 0;
		end
		deriv       = mv_first ? 0 : e - mv_last_err;
		mv_last_err = e;
		mv_first    = 1'b0;
		s = longint'(e) * longint'(cfg_now.gain_p)
		  + longint'(mv_integral) * longint'(cfg_now.gain_i)
		  + longint'(deriv) * longint'(cfg_now.gain_d);
		if (s <= longint'(SETTLE_LIMIT) && s >= -longint'(SETTLE_LIMIT)) begin
			mv_active = 1'b0;
			r.done    = 1'b1;
			r.cause   = CAUSE_SETTLED;
			return r;
		end
		lo = longint'(cfg_now.min_drive) * DRIVE_ONE;
		hi = longint'(cfg_now.max_drive) * DRIVE_ONE;
		c  = (s < 0) ? -s : s;
		if (c < lo)
			c = lo;
		if (c > hi)
			c = hi;
		prod = c * longint'($signed(cfg_now.drive_scale));
		pmag = (prod < 0) ? -prod : prod;
		pmag = pmag >> SCALE_SHIFT;
		if (pmag > 127)
			pmag = 127;
		if ((s < 0) != (prod < 0))
			pmag = -pmag;
		if (mv_ticks < int'(TICK_MAX))
			mv_ticks++;
		if (mv_ticks >= int'(cfg_now.timeout_ticks)) begin
			mv_active = 1'b0;
			r.done    = 1'b1;
			r.cause   = CAUSE_TIMEOUT;
			return r;
		end
		r.drive = pmag[7:0];
		return r;
	endfunction

	// Returns at the accepting edge with tvalid still high
	task automatic send_tick(bit start, logic signed [15:0] tgt, logic signed [15:0] meas);
		@(negedge clk);
		while (!gapless && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= start;
		s_tdata  <= {meas, tgt};
		do
			@(posedge clk);
		while (!s_tready);
		pending_ticks.push_back(heading_step(start, tgt, meas));
		n_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		// a running tick may still be in flight behind the last result
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GAIN_P:    cfg_now.gain_p         = val[15:0];
			REG_GAIN_I:    cfg_now.gain_i         = val[15:0];
			REG_GAIN_D:    cfg_now.gain_d         = val[15:0];
			REG_INT_LIMIT: cfg_now.integral_limit = val[15:0];
			REG_MIN_DRIVE: cfg_now.min_drive      = val[6:0];
			REG_MAX_DRIVE: cfg_now.max_drive      = val[6:0];
			REG_SCALE:     cfg_now.drive_scale    = val[15:0];
			REG_TIMEOUT:   cfg_now.timeout_ticks  = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(cfg_t c);
		wait_idle();
		write_reg(REG_GAIN_P,    {16'd0, c.gain_p});
		write_reg(REG_GAIN_I,    {16'd0, c.gain_i});
		write_reg(REG_GAIN_D,    {16'd0, c.gain_d});
		write_reg(REG_INT_LIMIT, {16'd0, c.integral_limit});
		write_reg(REG_MIN_DRIVE, {25'd0, c.min_drive});
		write_reg(REG_MAX_DRIVE, {25'd0, c.max_drive});
		write_reg(REG_SCALE,     {16'd0, c.drive_scale});
		write_reg(REG_TIMEOUT,   {16'd0, c.timeout_ticks});
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		logic [6:0] t;
		c.gain_p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32, 1024));
		c.gain_i = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
		c.gain_d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
		c.integral_limit = 16'($urandom);
		c.min_drive = 7'($urandom_range(127));
		c.max_drive = 7'($urandom_range(127));
		if ($urandom_range(3) != 0 && c.min_drive > c.max_drive) begin
			t           = c.min_drive;
			c.min_drive = c.max_drive;
			c.max_drive = t;
		end
		c.drive_scale = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(128, 512));
		case ($urandom_range(2))
			0:       c.timeout_ticks = 16'($urandom_range(1, 8));
			1:       c.timeout_ticks = 16'($urandom_range(20, 200));
			default: c.timeout_ticks = 16'hFFFF;
		endcase
		return c;
	endfunction

	// One turn: start, then an error that mostly shrinks, now and then overshoots
	task automatic run_move(int len);
		logic signed [15:0] tgt;
		int err, k;
		tgt = 16'($urandom);
		case ($urandom_range(3))
			0:       err = int'($urandom_range(400)) - 200;
			1:       err = int'($urandom_range(6000)) - 3000;
			2:       err = int'($urandom_range(24000)) - 12000;
			default: err = int'($urandom_range(131070)) - 65535;
		endcase
		send_tick(1'b1, tgt, tgt + 16'(err));
		for (k = 1; k < len; k++) begin
			if ($urandom_range(7) == 0)
				err = -err / 2 - 5;
			else
				err = err - err * int'($urandom_range(1, 7)) / 8
				    + int'($urandom_range(40)) - 20;
			send_tick(1'b0, tgt, tgt + 16'(err));
		end
	endtask

	task automatic test_directed();
		cfg_t c;
		// runs from reset without a start
		send_tick(1'b0, 16'sd0, 16'sd2000);
		send_tick(1'b0, 16'sd0, 16'sd1500);
		send_tick(1'b0, 16'sd0, -16'sd1500);
		send_tick(1'b0, 16'sd0, 16'sd1500);
		// move over: idle until restarted
		send_tick(1'b0, 16'sd0, 16'sd5000);
		send_tick(1'b1, 16'sd0, 16'sd30);
		send_tick(1'b1, -16'sd32768, 16'sd32767);
		send_tick(1'b1, 16'sd32767, -16'sd32768);
		send_tick(1'b1, 16'sd0, 16'sd11520);
		send_tick(1'b1, 16'sd0, 16'sd11521);
		send_tick(1'b1, 16'sd0, -16'sd11520);
		send_tick(1'b1, 16'sd0, -16'sd11521);
		send_tick(1'b1, 16'sd100, 16'sd100);
		send_tick(1'b1, 16'sd0, -16'sd1);
		c = cfg_now;
		c.gain_i = 16'd256;
		c.gain_d = 16'd128;
		set_config(c);
		// deadband edges and the integration threshold inside one move
		send_tick(1'b1, 16'sd0, 16'sd2000);
		send_tick(1'b0, 16'sd0, 16'sd97);
		send_tick(1'b0, 16'sd0, 16'sd96);
		send_tick(1'b0, 16'sd0, 16'sd639);
		send_tick(1'b0, 16'sd0, 16'sd640);
		send_tick(1'b0, 16'sd0, 16'sd3000);
		send_tick(1'b1, 16'sd0, -16'sd97);
		send_tick(1'b0, 16'sd0, -16'sd96);
	endtask

	task automatic test_register_extremes();
		cfg_t corners[4];
		int i, k;
		corners[0] = '{gain_p: 16'hFFFF, gain_i: 16'hFFFF, gain_d: 16'hFFFF,
			integral_limit: 16'h7FFF, min_drive: 7'd127, max_drive: 7'd127,
			drive_scale: 16'h7FFF, timeout_ticks: 16'hFFFF};
		corners[1] = '{gain_p: 16'd0, gain_i: 16'd0, gain_d: 16'd0,
			integral_limit: 16'h8000, min_drive: 7'd0, max_drive: 7'd0,
			drive_scale: 16'h8000, timeout_ticks: 16'd1};
		// bounds reversed, negative scale, short timeout
		corners[2] = '{gain_p: 16'd256, gain_i: 16'd16, gain_d: 16'd64,
			integral_limit: 16'd640, min_drive: 7'd100, max_drive: 7'd20,
			drive_scale: 16'hFF00, timeout_ticks: 16'd3};
		corners[3] = '{gain_p: 16'd512, gain_i: 16'd0, gain_d: 16'd4096,
			integral_limit: 16'h8000, min_drive: 7'd0, max_drive: 7'd127,
			drive_scale: 16'h8000, timeout_ticks: 16'd1};
		for (i = 0; i < 4; i++) begin
			set_config(corners[i]);
			for (k = 0; k < 6; k++)
				run_move($urandom_range(2, 6));
		end
	endtask

	// Hold a large error until the integral clips at both ends
	task automatic test_integral_saturation();
		int k;
		set_config('{gain_p: 16'd1, gain_i: 16'd1, gain_d: 16'd0,
			integral_limit: 16'h7FFF, min_drive: 7'd0, max_drive: 7'd127,
			drive_scale: 16'd256, timeout_ticks: 16'hFFFF});
		for (k = 0; k < 260; k++)
			send_tick(k == 0, -16'sd32768, 16'sd23038);
		for (k = 0; k < 260; k++)
			send_tick(k == 0, 16'sd32767, -16'sd32768);
	endtask

	task automatic test_backpressure();
		hold_req = 300;
		run_move(40);
	endtask

	task automatic test_random_moves(int n);
		int stop, quiet_at;
		stop     = n_sent + n;
		quiet_at = n_sent + n / 2;
		while (n_sent < stop) begin
			gapless = (n_sent >= quiet_at && n_sent < quiet_at + 200);
			if (!gapless && $urandom_range(9) == 0)
				set_config(random_cfg());
			if ($urandom_range(99) < 15)
				send_tick(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
			else
				run_move($urandom_range(3, 25));
		end
		gapless = 1'b0;
	endtask

	// Result side: random stalls, plus a long hold when one is requested
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= gapless || ($urandom_range(99) >= 17);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_ticks.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: drive %0d done %0b cause %0d",
						$signed(m_tdata), m_tlast, m_tuser);
			end else begin
				got_want = pending_ticks.pop_front();
				if (m_tdata !== got_want.drive || m_tlast !== got_want.done ||
						m_tuser !== got_want.cause) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch at %0t: drive %0d/%0d done %0b/%0b cause %0d/%0d",
							$realtime, got_want.drive, $signed(m_tdata), got_want.done,
							m_tlast, got_want.cause, m_tuser);
				end
			end
		end
	end

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		cfg_now  = '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
			integral_limit: RST_INT_LIMIT, min_drive: RST_MIN_DRIVE,
			max_drive: RST_MAX_DRIVE, drive_scale: RST_SCALE,
			timeout_ticks: RST_TIMEOUT};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_extremes();
		test_integral_saturation();
		test_backpressure();
		test_random_moves(760);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_bad == 0 && pending_ticks.size() == 0)
			$display("PASS heading_turn_pid");
		else
			$display("FAIL heading_turn_pid");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAIL heading_turn_pid");
		$finish;
	end

endmodule
